// File: rtl/core/wsf_pkg.sv
// Shared types and constants for the weighted 3x3 smoothing filter.
// Used by every module of the filter; depends on nothing else.
`default_nettype none

package wsf_pkg;

	localparam int PIX_W     = 8;
	localparam int ROW_W     = 10;
	localparam int COL_W     = 6;
	localparam int OUT_COL_W = 5;
	localparam int SUM_W     = 12;
	localparam int PROD_W    = 2 * SUM_W;

	localparam int MAX_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH   = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam logic [COL_W-1:0] WIDTH_RST  = 6'd15;
	localparam logic [ROW_W-1:0] HEIGHT_RST = 10'd15;
	localparam logic [COL_W-1:0] WIDTH_MIN  = 6'd3;
	localparam logic [ROW_W-1:0] HEIGHT_MIN = 10'd3;

	// floor(x / 10) == (x * 3277) >> 15 for every weighted sum the window can form.
	localparam logic [SUM_W-1:0] RECIP_10    = 12'd3277;
	localparam int               RECIP_SHIFT = 15;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             emit_left;
		logic             smooth;
		logic             emit_edge;
		logic             last;
	} item_t;

endpackage

`default_nettype wire

// File: rtl/core/wsf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on wsf_pkg for its default sizes; holds the line stores of the filter.
`default_nettype none

module wsf_ram #(
	parameter int WIDTH = wsf_pkg::PIX_W,
	parameter int DEPTH = wsf_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/wsf_front.sv
// Front end: configuration registers, frame position counters and item classification.
// Depends on wsf_pkg.
`default_nettype none

module wsf_front #(
	parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [wsf_pkg::PIX_W-1:0]        pixel_in,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [wsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wsf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             q_full,
	output logic                                  push,
	output wsf_pkg::item_t                        push_item,
	output logic [wsf_pkg::COL_W-1:0]             width_used
);
	import wsf_pkg::*;

	localparam int WCAP = (MAX_WIDTH > (2 ** COL_W) - 1) ? (2 ** COL_W) - 1 : MAX_WIDTH;

	logic [COL_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [ROW_W-1:0] height_used;
	logic             wrap;
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] cur_row;
	logic             at_right;
	logic             at_bottom;
	logic             cfg_hit;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign push      = in_valid && in_ready;

	always_comb begin
		if (width_q < WIDTH_MIN) begin
			width_used = WIDTH_MIN;
		end else if (width_q > COL_W'(WCAP)) begin
			width_used = COL_W'(WCAP);
		end else begin
			width_used = width_q;
		end
		height_used = (height_q < HEIGHT_MIN) ? HEIGHT_MIN : height_q;
	end

	always_comb begin
		wrap      = (col_q >= width_used) || (row_q >= height_used);
		cur_col   = wrap ? '0 : col_q;
		cur_row   = wrap ? '0 : row_q;
		at_right  = (cur_col == width_used - COL_W'(1));
		at_bottom = (cur_row == height_used - ROW_W'(1));

		push_item.pix       = pixel_in;
		push_item.row       = cur_row;
		push_item.col       = cur_col;
		push_item.emit_left = (cur_row != '0) && (cur_col != '0);
		push_item.smooth    = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
		push_item.emit_edge = (cur_row != '0) && at_right;
		push_item.last      = at_bottom && at_right;
	end

	always_comb begin
		case (cfg_index)
			CFG_IMAGE_WIDTH:  cfg_hit = cfg_valid;
			CFG_IMAGE_HEIGHT: cfg_hit = cfg_valid;
			default:          cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[COL_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// A write to either size register restarts the frame position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (at_right) begin
				col_q <= '0;
				row_q <= at_bottom ? '0 : cur_row + ROW_W'(1);
			end else begin
				col_q <= cur_col + COL_W'(1);
				row_q <= cur_row;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/wsf_queue.sv
// Short register queue of classified pixels between the front and back ends.
// Depends on wsf_pkg.
`default_nettype none

module wsf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire wsf_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output wsf_pkg::item_t      head_item,
	output logic                not_empty
);
	import wsf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/wsf_back.sv
// Back end: line stores, 3x3 window, weighted sum and divide by ten, result sequencing.
// Depends on wsf_pkg and wsf_ram.
`default_nettype none

module wsf_back #(
	parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_valid,
	input  wire wsf_pkg::item_t                 head_item,
	output logic                                pop,
	input  wire logic [wsf_pkg::COL_W-1:0]      width_used,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [wsf_pkg::PIX_W-1:0]           pixel_out,
	output logic [wsf_pkg::ROW_W-1:0]           out_row,
	output logic [wsf_pkg::OUT_COL_W-1:0]       out_col,
	output logic                                last_of_run,
	output logic                                frame_done
);
	import wsf_pkg::*;

	localparam int ADDR_W = $clog2(MAX_WIDTH);

	localparam logic [1:0] PH_LEFT  = 2'd0;
	localparam logic [1:0] PH_EDGE  = 2'd1;
	localparam logic [1:0] PH_FLUSH = 2'd2;

	// Stage 1: line store data arrives, window sum is formed.
	logic             valid_s1;
	item_t            item_s1;
	logic [PIX_W-1:0] up_rd;
	logic [PIX_W-1:0] mid_rd;
	logic [PIX_W-1:0] win_q [6];
	logic [SUM_W-1:0] sum_s1;
	logic             has_s1;
	logic             adv_s1;

	// Stage 2: divide and hand out the results of one item.
	logic             valid_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [PIX_W-1:0] centre_s2;
	logic [PIX_W-1:0] mid_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic             smooth_s2;
	logic             edge_s2;
	logic             last_s2;
	logic [1:0]       phase_q;
	logic [COL_W-1:0] fcol_q;
	logic             rd_ok_q;

	logic [PROD_W-1:0] prod;
	logic [PIX_W-1:0]  quot;
	logic [COL_W-1:0]  col_m1;
	logic              res_valid;
	logic [PIX_W-1:0]  res_pix;
	logic [ROW_W-1:0]  res_row;
	logic [OUT_COL_W-1:0] res_col;
	logic              res_final;
	logic              res_fdone;
	logic              emit;
	logic              done_s2;
	logic              flush_rd;
	logic [COL_W-1:0]  flush_col;

	logic             out_valid_q;
	logic [PIX_W-1:0] pix_out_q;
	logic [ROW_W-1:0] row_out_q;
	logic [OUT_COL_W-1:0] col_out_q;
	logic             lor_q;
	logic             fdone_q;

	// Stage 1 control
	assign has_s1 = item_s1.emit_left || item_s1.emit_edge || item_s1.last;
	assign adv_s1 = valid_s1 && (!has_s1 || !valid_s2 || done_s2);
	assign pop    = q_valid && (!valid_s1 || adv_s1) && !(valid_s1 && item_s1.last)
		&& !(valid_s2 && last_s2);

	assign flush_col = rd_ok_q ? fcol_q + COL_W'(1) : fcol_q;
	assign flush_rd  = valid_s2 && (phase_q == PH_FLUSH) && (!rd_ok_q || (emit && !res_final));

	wsf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (ADDR_W'(item_s1.col)),
		.wr_data (mid_rd),
		.rd_en   (pop),
		.rd_addr (ADDR_W'(head_item.col)),
		.rd_data (up_rd)
	);

	wsf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (ADDR_W'(item_s1.col)),
		.wr_data (item_s1.pix),
		.rd_en   (pop || flush_rd),
		.rd_addr (pop ? ADDR_W'(head_item.col) : ADDR_W'(flush_col)),
		.rd_data (mid_rd)
	);

	assign sum_s1 = SUM_W'({win_q[4], 1'b0}) + SUM_W'(win_q[0]) + SUM_W'(win_q[1])
		+ SUM_W'(win_q[2]) + SUM_W'(win_q[3]) + SUM_W'(win_q[5])
		+ SUM_W'(up_rd) + SUM_W'(mid_rd) + SUM_W'(item_s1.pix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head_item;
		end
		if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up_rd;
			win_q[4] <= mid_rd;
			win_q[5] <= item_s1.pix;
		end
	end

	// Stage 2 result selection
	assign prod   = PROD_W'(sum_s2) * PROD_W'(RECIP_10);
	assign quot   = prod[RECIP_SHIFT +: PIX_W];
	assign col_m1 = col_s2 - COL_W'(1);

	always_comb begin
		res_valid = 1'b0;
		res_pix   = '0;
		res_row   = '0;
		res_col   = '0;
		res_final = 1'b0;
		res_fdone = 1'b0;
		case (phase_q)
			PH_LEFT: begin
				res_valid = 1'b1;
				res_pix   = smooth_s2 ? quot : centre_s2;
				res_row   = row_s2 - ROW_W'(1);
				res_col   = col_m1[OUT_COL_W-1:0];
				res_final = !edge_s2 && !last_s2;
			end
			PH_EDGE: begin
				res_valid = 1'b1;
				res_pix   = mid_s2;
				res_row   = row_s2 - ROW_W'(1);
				res_col   = col_s2[OUT_COL_W-1:0];
				res_final = !last_s2;
			end
			PH_FLUSH: begin
				res_valid = rd_ok_q;
				res_pix   = mid_rd;
				res_row   = row_s2;
				res_col   = fcol_q[OUT_COL_W-1:0];
				res_final = (fcol_q == width_used - COL_W'(1));
				res_fdone = res_final;
			end
			default: ;
		endcase
	end

	assign emit    = valid_s2 && res_valid && (!out_valid_q || out_ready);
	assign done_s2 = emit && res_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_q  <= PH_LEFT;
			fcol_q   <= '0;
			rd_ok_q  <= 1'b0;
		end else if (adv_s1 && has_s1) begin
			valid_s2 <= 1'b1;
			fcol_q   <= '0;
			rd_ok_q  <= 1'b0;
			if (item_s1.emit_left) begin
				phase_q <= PH_LEFT;
			end else if (item_s1.emit_edge) begin
				phase_q <= PH_EDGE;
			end else begin
				phase_q <= PH_FLUSH;
			end
		end else begin
			if (done_s2) begin
				valid_s2 <= 1'b0;
				rd_ok_q  <= 1'b0;
			end else if (flush_rd) begin
				rd_ok_q <= 1'b1;
			end
			if (emit && !res_final) begin
				case (phase_q)
					PH_LEFT:  phase_q <= edge_s2 ? PH_EDGE : PH_FLUSH;
					PH_EDGE:  phase_q <= PH_FLUSH;
					PH_FLUSH: fcol_q  <= fcol_q + COL_W'(1);
					default:  phase_q <= PH_LEFT;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_s1) begin
			sum_s2    <= sum_s1;
			centre_s2 <= win_q[4];
			mid_s2    <= mid_rd;
			row_s2    <= item_s1.row;
			col_s2    <= item_s1.col;
			smooth_s2 <= item_s1.smooth;
			edge_s2   <= item_s1.emit_edge;
			last_s2   <= item_s1.last;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_out_q <= res_pix;
			row_out_q <= res_row;
			col_out_q <= res_col;
			lor_q     <= res_final;
			fdone_q   <= res_fdone;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pix_out_q;
	assign out_row     = row_out_q;
	assign out_col     = col_out_q;
	assign last_of_run = lor_q;
	assign frame_done  = fdone_q;

`ifndef SYNTHESIS
	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && flush_rd))
		else $error("line store read port claimed twice");

	a_flush_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |-> !valid_s1)
		else $error("pixel in stage 1 while the final row is flushed");

	a_rdok_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ok_q |-> (valid_s2 && phase_q == PH_FLUSH))
		else $error("flush read data outside the flush phase");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fdone_q) |-> lor_q)
		else $error("frame end without end of run");
`endif

endmodule

`default_nettype wire

// File: rtl/core/weighted_3x3_smoothing_filter_top.sv
// Top level of the weighted 3x3 smoothing filter: front end, queue and back end.
// Depends on wsf_pkg, wsf_front, wsf_queue and wsf_back (which uses wsf_ram).
//
// Channel   Signals                                              Direction
// -------   --------------------------------------------------   ---------
// input     in_valid, in_ready, pixel_in                         in
// output    out_valid, out_ready, pixel_out, out_row, out_col,   out
//           last_of_run, frame_done
// config    cfg_valid, cfg_ready, cfg_index, cfg_data            in
//
// Flow: within a row one pixel beat per clock is taken while the queue is not full. A
// pixel in the last column of any row but the first gives two output beats and holds
// the back end for both, so a continuous stream sees input stalls once the queue is full.
// The frame's last pixel gives its own results plus one beat per column of the final
// row, after a line store read; no new pixel enters the back end until that flush is
// done. The flush reads the final row through the single read port of the middle line
// store. Reset clears the counters, the queue and all valid flags; the line stores
// need no clearing pass. Either side may stall at any time: the queue lets the front
// keep taking pixels while the back waits on out_ready.
`default_nettype none

module weighted_3x3_smoothing_filter_top #(
	parameter int MAX_WIDTH = wsf_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [wsf_pkg::PIX_W-1:0]      pixel_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [wsf_pkg::PIX_W-1:0]           pixel_out,
	output logic [wsf_pkg::ROW_W-1:0]           out_row,
	output logic [wsf_pkg::OUT_COL_W-1:0]       out_col,
	output logic                                last_of_run,
	output logic                                frame_done,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [wsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wsf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wsf_pkg::*;

	// The front classifies each pixel by its place in the frame.
	logic             push;
	item_t            push_item;
	logic             q_full;
	logic             q_valid;
	logic             pop;
	item_t            head_item;
	logic [COL_W-1:0] width_used;

	wsf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_in   (pixel_in),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item),
		.width_used (width_used)
	);

	// The queue decouples input stalls from output stalls.
	wsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_item (head_item),
		.not_empty (q_valid)
	);

	// The back reads the line stores, forms the weighted sum and sequences the
	// output beats of each pixel: none, one, two or more.
	wsf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.head_item   (head_item),
		.pop         (pop),
		.width_used  (width_used),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_out   (pixel_out),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

endmodule

`default_nettype wire

// File: dv/tb_weighted_3x3_smoothing_filter_top.sv
// Self-checking testbench for weighted_3x3_smoothing_filter_top.
// It predicts every output beat from the accepted pixel and register beats, and
// checks them in order. It depends only on wsf_pkg and the filter RTL.
`default_nettype none

module tb_weighted_3x3_smoothing_filter_top;

	import wsf_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 10;
	localparam int TIMEOUT_CYCLES = 400_000;
	// Quiet cycles that must pass before a register write and before the end.
	// They cover the pipeline with a good margin, since a pixel in the top row
	// produces no output beat to wait for.
	localparam int SETTLE_CYCLES  = 12;
	localparam int PIXEL_TARGET   = 210;
	localparam int MAX_SHOWN      = 20;
	localparam int FILTER_WIDTH   = MAX_WIDTH_DEF;
	localparam int CENTRE_WEIGHT  = 2;
	localparam int SMOOTH_DIVISOR = 10;

	// An index that names no register. A write to it must change nothing,
	// not even the frame position.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum logic {
		ENTRY_PIXEL,
		ENTRY_REG
	} entry_kind_t;

	typedef struct {
		entry_kind_t             kind;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [CFG_DATA_W-1:0]   reg_data;
		logic [PIX_W-1:0]        pix;
	} stim_entry_t;

	typedef struct packed {
		logic [PIX_W-1:0]     val_px;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic                 run_end;
		logic                 frame_end;
	} pix_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	// Clock, reset and the signals that drive the block. Every input starts at a
	// known value so nothing floats before the reset branches take over.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid  = 1'b0;
	logic [PIX_W-1:0]      pixel_in  = '0;
	logic                  out_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	wire logic                 in_ready;
	wire logic                 out_valid;
	wire logic [PIX_W-1:0]     pixel_out;
	wire logic [ROW_W-1:0]     out_row;
	wire logic [OUT_COL_W-1:0] out_col;
	wire logic                 last_of_run;
	wire logic                 frame_done;
	wire logic                 cfg_ready;

	always #(CLK_PERIOD / 2) clk = ~clk;

	weighted_3x3_smoothing_filter_top #(
		.MAX_WIDTH(FILTER_WIDTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.out_row    (out_row),
		.out_col    (out_col),
		.last_of_run(last_of_run),
		.frame_done (frame_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Stimulus waiting to be driven, and output beats waiting to be seen.
	stim_entry_t pending_q[$];
	pix_result_t due_pixels[$];

	// Shadow copy of the filter state. line_above2 and line_above1 mirror the two
	// line stores, win_px the two previous window columns (top, middle, bottom).
	logic [PIX_W-1:0]  line_above2 [FILTER_WIDTH];
	logic [PIX_W-1:0]  line_above1 [FILTER_WIDTH];
	logic [PIX_W-1:0]  win_px [6];
	int unsigned       pos_row;
	int unsigned       pos_col;
	logic [COL_W-1:0]  width_cfg;
	logic [ROW_W-1:0]  height_cfg;

	int idle_cycles;
	int failures;
	int pixel_beats;
	int checked_beats;
	int frames_closed;
	int reg_writes;
	int planned_pixels;

	// Out-of-range sizes are clamped: a width to [3, FILTER_WIDTH], a height
	// below three up to three.
	function automatic int unsigned eff_width(input logic [COL_W-1:0] wc);
		if (wc < WIDTH_MIN)
			return WIDTH_MIN;
		if (wc > FILTER_WIDTH)
			return FILTER_WIDTH;
		return wc;
	endfunction

	function automatic int unsigned eff_height(input logic [ROW_W-1:0] hc);
		if (hc < HEIGHT_MIN)
			return HEIGHT_MIN;
		return hc;
	endfunction

	function automatic pix_result_t make_result(input logic [SUM_W-1:0] val,
			input int unsigned row, input int unsigned col);
		pix_result_t res;
		res.val_px    = val[PIX_W-1:0];
		res.row       = row[ROW_W-1:0];
		res.col       = col[OUT_COL_W-1:0];
		res.run_end   = 1'b0;
		res.frame_end = 1'b0;
		return res;
	endfunction

	// Takes one accepted pixel and queues the output beats it releases. The
	// pixel up and to the left of the new one is complete once it arrives, the
	// right border pixel of the row above goes out with it in the last column,
	// and the frame's final pixel also flushes the whole bottom row.
	task automatic smooth_and_emit(input logic [PIX_W-1:0] p);
		int unsigned      w;
		int unsigned      h;
		int unsigned      r;
		int unsigned      c;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [SUM_W-1:0] val;
		pix_result_t      batch[$];
		w = eff_width(width_cfg);
		h = eff_height(height_cfg);
		if (pos_col >= w || pos_row >= h) begin
			pos_col = 0;
			pos_row = 0;
		end
		r = pos_row;
		c = pos_col;
		top = line_above2[c];
		mid = line_above1[c];
		line_above2[c] = mid;
		line_above1[c] = p;
		if (r >= 1 && c >= 1) begin
			val = SUM_W'(win_px[4]);
			if (r >= 2 && c >= 2) begin
				val = SUM_W'((CENTRE_WEIGHT * win_px[4] + win_px[0] + win_px[1] + win_px[2]
					+ win_px[3] + win_px[5] + top + mid + p) / SMOOTH_DIVISOR);
			end
			batch.push_back(make_result(val, r - 1, c - 1));
		end
		if (r >= 1 && c == w - 1)
			batch.push_back(make_result(SUM_W'(mid), r - 1, c));
		win_px[0] = win_px[3];
		win_px[1] = win_px[4];
		win_px[2] = win_px[5];
		win_px[3] = top;
		win_px[4] = mid;
		win_px[5] = p;
		if (r == h - 1 && c == w - 1) begin
			for (int unsigned j = 0; j < w; j++)
				batch.push_back(make_result(SUM_W'(line_above1[j]), r, j));
			batch[batch.size() - 1].frame_end = 1'b1;
		end
		if (batch.size() != 0)
			batch[batch.size() - 1].run_end = 1'b1;
		foreach (batch[k])
			due_pixels.push_back(batch[k]);
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		pos_col = c;
		pos_row = r;
	endtask

	// A write to either size register restarts the frame position; line and
	// window contents survive. A spare index is ignored entirely.
	task automatic write_dim_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_IMAGE_WIDTH: begin
				width_cfg = data[COL_W-1:0];
				pos_row = 0;
				pos_col = 0;
			end
			CFG_IMAGE_HEIGHT: begin
				height_cfg = data[ROW_W-1:0];
				pos_row = 0;
				pos_col = 0;
			end
			default: begin
			end
		endcase
	endtask

	// Stimulus planning. Register entries are held back by the driver until the
	// block has drained, so a phase boundary is simply a register entry.
	task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		stim_entry_t e;
		e.kind     = ENTRY_REG;
		e.reg_idx  = idx;
		e.reg_data = data;
		e.pix      = '0;
		pending_q.push_back(e);
	endtask

	task automatic add_pixel(input logic [PIX_W-1:0] p);
		stim_entry_t e;
		e.kind     = ENTRY_PIXEL;
		e.reg_idx  = '0;
		e.reg_data = '0;
		e.pix      = p;
		pending_q.push_back(e);
		planned_pixels++;
	endtask

	// Random pixels lean toward the two extremes so that saturated windows and
	// empty windows turn up often.
	task automatic add_pixels(input int n);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 7);
			if (sel == 0)
				add_pixel('0);
			else if (sel == 1)
				add_pixel('1);
			else
				add_pixel(PIX_W'($urandom_range(0, 255)));
		end
	endtask

	// Writes both size registers in random order. The width beat carries random
	// upper bits, which the block must drop.
	task automatic add_dims(input logic [COL_W-1:0] wd, input logic [ROW_W-1:0] hd);
		logic [CFG_DATA_W-1:0] wdata;
		wdata = {4'($urandom_range(0, 15)), wd};
		if ($urandom_range(0, 1) == 0) begin
			add_reg(CFG_IMAGE_WIDTH, wdata);
			add_reg(CFG_IMAGE_HEIGHT, hd);
		end else begin
			add_reg(CFG_IMAGE_HEIGHT, hd);
			add_reg(CFG_IMAGE_WIDTH, wdata);
		end
	endtask

	task automatic plan_stimulus();
		logic [COL_W-1:0] wd;
		logic [ROW_W-1:0] hd;
		int               frame_px;
		int               sel;
		// Reset sizes first: enough of a 15-wide frame to reach the second row.
		add_pixels(17);
		// Smallest frame, every pixel at full scale: the largest weighted sum.
		add_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
		add_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
		repeat (9) add_pixel('1);
		// Width zero and height two clamp to a 3x3 frame. A single bright centre
		// gives twice its value over ten. The spare-index write in the middle of
		// the frame must not restart it.
		add_reg(CFG_IMAGE_WIDTH, 10'h3C0);
		add_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
		repeat (4) add_pixel('0);
		add_reg(CFG_SPARE, '1);
		add_pixel('1);
		repeat (4) add_pixel('0);
		// Widest frame (width 63 clamps to the maximum) taken to its end, so the
		// final pixel releases the longest run of beats.
		add_dims(6'd63, 10'd3);
		add_pixels(FILTER_WIDTH * 3);
		// The tallest frame, only partly fed.
		add_dims(6'd3, 10'd1023);
		add_pixels(20);
		// Random phases: mostly whole frames that wrap into the next one, some
		// partial frames that the next register write cuts short. A whole frame
		// is only planned where it keeps the total near the target.
		while (planned_pixels < PIXEL_TARGET) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				wd = COL_W'($urandom_range(0, 2));
			else if (sel == 1)
				wd = COL_W'($urandom_range(33, 63));
			else if (sel == 2)
				wd = COL_W'(FILTER_WIDTH);
			else
				wd = COL_W'($urandom_range(3, 12));
			sel = $urandom_range(0, 9);
			if (sel == 0)
				hd = ROW_W'($urandom_range(0, 2));
			else if (sel == 1)
				hd = ROW_W'($urandom_range(512, 1023));
			else
				hd = ROW_W'($urandom_range(3, 6));
			add_dims(wd, hd);
			frame_px = eff_width(wd) * eff_height(hd);
			if (frame_px <= 100 && planned_pixels + frame_px <= PIXEL_TARGET + 20
					&& $urandom_range(0, 3) != 0)
				add_pixels(frame_px + $urandom_range(0, eff_width(wd)));
			else
				add_pixels($urandom_range(5, 40));
		end
	endtask

	// Sender. It pushes pixels in bursts of random length with random gaps,
	// and now and then a long burst with no gaps at all. A register entry waits
	// until the block has been quiet for SETTLE_CYCLES; the check on in_valid
	// keeps a write from following a pixel that was accepted at this very edge.
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			pixel_in  <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
			burst_left = 1;
			gap_left   = 0;
		end else if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
			// The beat on offer has not been taken yet, so it stays as it is.
		end else if (gap_left > 0) begin
			gap_left = gap_left - 1;
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else if (pending_q.size() == 0) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else if (pending_q[0].kind == ENTRY_REG) begin
			in_valid <= 1'b0;
			if (!in_valid && idle_cycles >= SETTLE_CYCLES) begin
				cfg_valid <= 1'b1;
				cfg_index <= pending_q[0].reg_idx;
				cfg_data  <= pending_q[0].reg_data;
				pending_q.pop_front();
			end else begin
				cfg_valid <= 1'b0;
			end
		end else begin
			cfg_valid <= 1'b0;
			in_valid  <= 1'b1;
			pixel_in  <= pending_q[0].pix;
			pending_q.pop_front();
			burst_left = burst_left - 1;
			if (burst_left == 0) begin
				if ($urandom_range(0, 4) == 0) begin
					burst_left = 60;
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15)
						: $urandom_range(0, 3);
				end
			end
		end
	end

	// Receiver. It switches at random times between always ready, a
	// rotating fixed stall pattern, and a mostly stalled random mode.
	logic [12:0] ready_pattern;
	rx_mode_t    rx_mode;
	int          mode_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_pattern = 13'b1_1011_0011_1011;
			rx_mode       = RX_OPEN;
			mode_left     = 0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 80);
			end
			mode_left = mode_left - 1;
			ready_pattern = {ready_pattern[11:0], ready_pattern[12]};
			case (rx_mode)
				RX_OPEN:    out_ready <= 1'b1;
				RX_PATTERN: out_ready <= ready_pattern[0];
				default:    out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Monitor. Everything is sampled at the rising edge, so it sees the values
	// that were stable before the edge. Input and register beats update the
	// shadow state first; an output beat in the same cycle always belongs to an
	// earlier pixel because of the pipeline latency.
	pix_result_t seen_px;
	pix_result_t want_px;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FILTER_WIDTH; i++) begin
				line_above2[i] = '0;
				line_above1[i] = '0;
			end
			for (int i = 0; i < 6; i++)
				win_px[i] = '0;
			pos_row    = 0;
			pos_col    = 0;
			width_cfg  = WIDTH_RST;
			height_cfg = HEIGHT_RST;
			idle_cycles <= 0;
		end else begin
			if (in_valid && in_ready) begin
				smooth_and_emit(pixel_in);
				pixel_beats++;
			end
			if (cfg_valid && cfg_ready) begin
				write_dim_reg(cfg_index, cfg_data);
				reg_writes++;
			end
			if (out_valid && out_ready) begin
				seen_px = {pixel_out, out_row, out_col, last_of_run, frame_done};
				if (due_pixels.size() == 0) begin
					failures++;
					if (failures <= MAX_SHOWN)
						$display("%0t: unexpected output beat pix=%0d row=%0d col=%0d",
							$time, pixel_out, out_row, out_col);
				end else begin
					want_px = due_pixels.pop_front();
					checked_beats++;
					if (seen_px.val_px !== want_px.val_px
							|| seen_px.row !== want_px.row
							|| seen_px.col !== want_px.col
							|| seen_px.run_end !== want_px.run_end
							|| seen_px.frame_end !== want_px.frame_end) begin
						failures++;
						if (failures <= MAX_SHOWN)
							$display({"%0t: mismatch, expected pix=%0d row=%0d col=%0d last=%0b",
								" done=%0b, got pix=%0d row=%0d col=%0d last=%0b done=%0b"},
								$time, want_px.val_px, want_px.row, want_px.col,
								want_px.run_end, want_px.frame_end, seen_px.val_px,
								seen_px.row, seen_px.col, seen_px.run_end,
								seen_px.frame_end);
					end else if (want_px.frame_end) begin
						frames_closed++;
					end
				end
			end
			// Consecutive cycles with nothing on offer and nothing outstanding.
			if (due_pixels.size() == 0 && !in_valid && !cfg_valid)
				idle_cycles <= (idle_cycles < 1000) ? idle_cycles + 1 : idle_cycles;
			else
				idle_cycles <= 0;
		end
	end

	// Main sequence: plan, reset once, then wait for the stimulus to run out and
	// the block to drain. The check runs at the falling edge, where every
	// update of the rising edge has settled.
	initial begin
		failures       = 0;
		pixel_beats    = 0;
		checked_beats  = 0;
		frames_closed  = 0;
		reg_writes     = 0;
		planned_pixels = 0;
		plan_stimulus();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_q.size() != 0 || in_valid || cfg_valid || idle_cycles < SETTLE_CYCLES)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d pixel beats and %0d register writes.", pixel_beats, reg_writes);
		$display("Checked %0d output beats, including %0d completed frames.",
			checked_beats, frames_closed);
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog for a hung handshake or missing output beats.
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("Timeout with %0d output beats still expected.", due_pixels.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: weighted_3x3_smoothing_filter_top.f
rtl/core/wsf_pkg.sv
rtl/core/wsf_ram.sv
rtl/core/wsf_front.sv
rtl/core/wsf_queue.sv
rtl/core/wsf_back.sv
rtl/core/weighted_3x3_smoothing_filter_top.sv
dv/tb_weighted_3x3_smoothing_filter_top.sv
